// File: sv/dmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dmp_pkg;

  localparam logic [4:0] FC_ID        = 5'd0;
  localparam logic [4:0] FC_QR        = 5'd1;
  localparam logic [4:0] FC_OPCODE    = 5'd2;
  localparam logic [4:0] FC_AA        = 5'd3;
  localparam logic [4:0] FC_TC        = 5'd4;
  localparam logic [4:0] FC_RD        = 5'd5;
  localparam logic [4:0] FC_RA        = 5'd6;
  localparam logic [4:0] FC_Z         = 5'd7;
  localparam logic [4:0] FC_RCODE     = 5'd8;
  localparam logic [4:0] FC_QDCOUNT   = 5'd9;
  localparam logic [4:0] FC_ANCOUNT   = 5'd10;
  localparam logic [4:0] FC_NSCOUNT   = 5'd11;
  localparam logic [4:0] FC_ARCOUNT   = 5'd12;
  localparam logic [4:0] FC_NAME_CHAR = 5'd13;
  localparam logic [4:0] FC_NAME_END  = 5'd14;
  localparam logic [4:0] FC_TYPE      = 5'd15;
  localparam logic [4:0] FC_CLASS     = 5'd16;
  localparam logic [4:0] FC_TTL       = 5'd17;
  localparam logic [4:0] FC_RDLENGTH  = 5'd18;
  localparam logic [4:0] FC_RDATA     = 5'd19;

  localparam logic [7:0] DOT_CHAR = 8'h2e;

  // one record per input byte that yields results
  typedef enum logic [1:0] {
    REC_SINGLE,
    REC_FLAGS2,
    REC_FLAGS3
  } rec_kind_t;

  typedef struct packed {
    rec_kind_t   kind;
    logic [4:0]  code;
    logic [31:0] value;
  } rec_t;

endpackage

`default_nettype wire

// File: sv/dmp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dmp_front (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  [7:0]        in_byte,
  input  wire               in_start,
  input  wire               cfg_valid,
  input  wire               cfg_data,
  output logic              push_valid,
  input  wire               push_ready,
  output dmp_pkg::rec_t     push_data
);
  import dmp_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER, PH_LEN, PH_LABEL, PH_TYPE, PH_CLASS, PH_TTL, PH_RDLEN, PH_RDATA
  } phase_t;

  phase_t      phase, phase_e, phase_next;
  logic [3:0]  pos, pos_e, pos_next;
  logic [31:0] acc, acc_e, acc_next;
  logic [7:0]  lrem, lrem_e, lrem_next;
  logic        first, first_e, first_next;
  logic [15:0] rrem, rrem_e, rrem_next;
  logic        stopped, stopped_e, stopped_next;
  logic        kind;
  logic        has_rec;
  rec_t        rec;
  logic        accept;
  logic [15:0] word;
  logic [7:0]  lrem_dec;
  logic [15:0] rrem_dec;

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = accept && has_rec;
  assign push_data  = rec;

  always_comb begin
    phase_e   = in_start ? PH_HEADER : phase;
    pos_e     = in_start ? 4'd0 : pos;
    acc_e     = in_start ? 32'd0 : acc;
    lrem_e    = in_start ? 8'd0 : lrem;
    first_e   = in_start ? 1'b1 : first;
    rrem_e    = in_start ? 16'd0 : rrem;
    stopped_e = in_start ? 1'b0 : stopped;

    phase_next   = phase_e;
    pos_next     = pos_e;
    acc_next     = acc_e;
    lrem_next    = lrem_e;
    first_next   = first_e;
    rrem_next    = rrem_e;
    stopped_next = stopped_e;

    word     = {acc_e[7:0], in_byte};
    lrem_dec = lrem_e - 8'd1;
    rrem_dec = rrem_e - 16'd1;

    has_rec    = 1'b0;
    rec.kind   = REC_SINGLE;
    rec.code   = FC_ID;
    rec.value  = {24'd0, in_byte};

    if (!stopped_e) begin
      unique case (phase_e)
        PH_HEADER: begin
          if (pos_e == 4'd2) begin
            has_rec  = 1'b1;
            rec.kind = REC_FLAGS2;
          end else if (pos_e == 4'd3) begin
            has_rec  = 1'b1;
            rec.kind = REC_FLAGS3;
            if (kind && (in_byte[3:0] != 4'd0)) stopped_next = 1'b1;
          end else if (!pos_e[0]) begin
            acc_next = {24'd0, in_byte};
          end else begin
            has_rec   = 1'b1;
            rec.value = {16'd0, word};
            case (pos_e)
              4'd1:    rec.code = FC_ID;
              4'd5:    rec.code = FC_QDCOUNT;
              4'd7:    rec.code = FC_ANCOUNT;
              4'd9:    rec.code = FC_NSCOUNT;
              default: rec.code = FC_ARCOUNT;
            endcase
          end
          if (pos_e >= 4'd11) begin
            phase_next = PH_LEN;
            pos_next   = 4'd0;
          end else begin
            pos_next = pos_e + 4'd1;
          end
        end
        PH_LEN: begin
          if (in_byte == 8'd0) begin
            has_rec    = 1'b1;
            rec.code   = FC_NAME_END;
            rec.value  = 32'd0;
            phase_next = PH_TYPE;
            pos_next   = 4'd0;
          end else begin
            has_rec    = !first_e;
            rec.code   = FC_NAME_CHAR;
            rec.value  = {24'd0, DOT_CHAR};
            first_next = 1'b0;
            lrem_next  = in_byte;
            phase_next = PH_LABEL;
          end
        end
        PH_LABEL: begin
          has_rec   = 1'b1;
          rec.code  = FC_NAME_CHAR;
          lrem_next = lrem_dec;
          if (lrem_dec == 8'd0) phase_next = PH_LEN;
        end
        PH_TYPE, PH_CLASS, PH_RDLEN: begin
          if (pos_e == 4'd0) begin
            acc_next = {24'd0, in_byte};
            pos_next = 4'd1;
          end else begin
            has_rec   = 1'b1;
            rec.value = {16'd0, word};
            pos_next  = 4'd0;
            if (phase_e == PH_TYPE) begin
              rec.code   = FC_TYPE;
              phase_next = PH_CLASS;
            end else if (phase_e == PH_CLASS) begin
              rec.code = FC_CLASS;
              if (kind) phase_next = PH_TTL;
              else stopped_next = 1'b1;
            end else begin
              rec.code  = FC_RDLENGTH;
              rrem_next = word;
              if (word == 16'd0) stopped_next = 1'b1;
              else phase_next = PH_RDATA;
            end
          end
        end
        PH_TTL: begin
          acc_next = {acc_e[23:0], in_byte};
          if (pos_e >= 4'd3) begin
            has_rec    = 1'b1;
            rec.code   = FC_TTL;
            rec.value  = acc_next;
            pos_next   = 4'd0;
            phase_next = PH_RDLEN;
          end else begin
            pos_next = pos_e + 4'd1;
          end
        end
        PH_RDATA: begin
          has_rec   = 1'b1;
          rec.code  = FC_RDATA;
          rrem_next = rrem_dec;
          if (rrem_dec == 16'd0) stopped_next = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind    <= 1'b0;
      phase   <= PH_HEADER;
      pos     <= 4'd0;
      acc     <= 32'd0;
      lrem    <= 8'd0;
      first   <= 1'b1;
      rrem    <= 16'd0;
      stopped <= 1'b0;
    end else begin
      if (cfg_valid) kind <= cfg_data;
      if (accept) begin
        phase   <= phase_next;
        pos     <= pos_next;
        acc     <= acc_next;
        lrem    <= lrem_next;
        first   <= first_next;
        rrem    <= rrem_next;
        stopped <= stopped_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/dmp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module dmp_queue #(
  parameter int DEPTH = 4
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               push_valid,
  output logic              push_ready,
  input  dmp_pkg::rec_t     push_data,
  output logic              pop_valid,
  input  wire               pop_ready,
  output dmp_pkg::rec_t     pop_data
);
  import dmp_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rec_t             mem [DEPTH];
  logic [IDX_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push)
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + IDX_W'(1);
      if (do_pop)
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + IDX_W'(1);
      if (do_push && !do_pop) count <= count + CNT_W'(1);
      else if (!do_push && do_pop) count <= count - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: sv/dmp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module dmp_back (
  input  wire               clk,
  input  wire               rst,
  input  wire               head_valid,
  output logic              head_pop,
  input  dmp_pkg::rec_t     head,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [4:0]        out_code,
  output logic [31:0]       out_value,
  output logic              out_last
);
  import dmp_pkg::*;

  logic [2:0]  sub;
  logic [4:0]  x_code;
  logic [31:0] x_value;
  logic        x_last;
  logic        load;
  logic [7:0]  b;

  assign b        = head.value[7:0];
  assign load     = head_valid && (!out_valid || out_ready);
  assign head_pop = load && x_last;

  always_comb begin
    x_code  = head.code;
    x_value = head.value;
    x_last  = 1'b1;
    unique case (head.kind)
      REC_FLAGS2: begin
        x_last = (sub == 3'd4);
        case (sub)
          3'd0: begin x_code = FC_QR;     x_value = {31'd0, b[7]};   end
          3'd1: begin x_code = FC_OPCODE; x_value = {28'd0, b[6:3]}; end
          3'd2: begin x_code = FC_AA;     x_value = {31'd0, b[2]};   end
          3'd3: begin x_code = FC_TC;     x_value = {31'd0, b[1]};   end
          default: begin x_code = FC_RD;  x_value = {31'd0, b[0]};   end
        endcase
      end
      REC_FLAGS3: begin
        x_last = (sub == 3'd2);
        case (sub)
          3'd0: begin x_code = FC_RA;       x_value = {31'd0, b[7]};   end
          3'd1: begin x_code = FC_Z;        x_value = {29'd0, b[6:4]}; end
          default: begin x_code = FC_RCODE; x_value = {28'd0, b[3:0]}; end
        endcase
      end
      default: x_last = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 3'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sub       <= x_last ? 3'd0 : sub + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_code  <= x_code;
      out_value <= x_value;
      out_last  <= x_last;
    end
  end

endmodule

`default_nettype wire

// File: sv/dns_message_parser.sv
// DNS message parser.
// Input stream s_axis: one message byte per transaction; tuser marks the
// first byte of a message and restarts the parse there.
// Output stream m_axis: one field event per transaction; tuser is the field
// code, tdata the zero-extended value, tlast marks the last event of a byte.
// Config channel cfg: bit 0 selects question (0) or response (1) parsing;
// always ready; the user must write it only while the stream is idle.
// The block does not enforce it. Throughput: one byte per cycle on input
// while the record queue has room. Output moves one event per cycle while
// m_axis_tready is high; header flag bytes expand to five and three events,
// which the queue (QUEUE_DEPTH entries) absorbs while input continues.
// Stall: when m_axis_tready is low the output register holds, the queue
// fills, and s_axis_tready drops once it is full.
// Reset: synchronous; clears the parse to header byte 0, message_kind to
// question, and empties the queue and output register.
`timescale 1ns / 1ps
`default_nettype none

module dns_message_parser #(
  parameter int QUEUE_DEPTH = 8
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // msg_byte
  input  wire         s_axis_tuser,   // msg_start
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // field_value
  output logic [4:0]  m_axis_tuser,   // field_code
  output logic        m_axis_tlast,   // last_of_run
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         cfg_data        // message_kind
);
  import dmp_pkg::*;

  logic push_valid, push_ready, head_valid, head_pop;
  rec_t push_data, head;

  assign cfg_ready = 1'b1;

  dmp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_start   (s_axis_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  dmp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (head_valid),
    .pop_ready  (head_pop),
    .pop_data   (head)
  );

  dmp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .head       (head),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_code   (m_axis_tuser),
    .out_value  (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: sv/dmp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dmp_checker (
  input wire        clk,
  input wire        rst,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [31:0] m_axis_tdata,
  input wire [4:0]  m_axis_tuser,
  input wire        m_axis_tlast
);
  import dmp_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled output changed");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser <= FC_RDATA)
    else $error("field code out of range");

  a_flag_bits: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == FC_QR || m_axis_tuser == FC_AA ||
      m_axis_tuser == FC_TC || m_axis_tuser == FC_RD || m_axis_tuser == FC_RA)
      |-> m_axis_tdata[31:1] == 31'd0)
    else $error("one-bit flag wider than one bit");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == FC_RD || m_axis_tuser == FC_RCODE)
      |-> m_axis_tlast)
    else $error("flag byte run not closed");

endmodule

bind dns_message_parser dmp_checker u_dmp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: dv/dns_message_parser_test.sv
`timescale 1ns / 1ps

module dns_message_parser_test;
  import dmp_pkg::*;

  localparam int IDLE_LIMIT    = 1000;
  localparam int SETTLE_CYCLES = 10;

  typedef enum logic [3:0] {
    ST_HEADER,
    ST_NAME_LEN,
    ST_NAME_LABEL,
    ST_TYPE,
    ST_CLASS,
    ST_TTL,
    ST_RDLEN,
    ST_RDATA
  } parse_state_t;

  typedef struct {
    logic [7:0] octet;
    logic       start;
    logic       hold;
  } msg_octet_t;

  typedef struct {
    logic [4:0]  code;
    logic [31:0] value;
    logic        last;
  } field_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [4:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  dns_message_parser DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),    // msg_byte
    .s_axis_tuser  (s_axis_tuser),    // msg_start
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),    // field_value
    .m_axis_tuser  (m_axis_tuser),    // field_code
    .m_axis_tlast  (m_axis_tlast),    // last_of_run
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)         // message_kind
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser model state
  logic         resp_mode;
  parse_state_t parse_state;
  logic [3:0]   hdr_pos;
  logic [31:0]  word_acc;
  logic [7:0]   label_left;
  logic         first_label;
  logic [15:0]  rdata_left;
  logic         halted;

  field_event_t step_evs[$];
  field_event_t event_q[$];
  msg_octet_t   octet_q[$];

  int  octets_pushed = 0;
  int  octets_taken  = 0;
  int  errors        = 0;
  int  idle_cycles   = 0;
  int  rx_cycle      = 0;
  int  burst_left    = 1;
  int  gap_left      = 0;
  bit  in_accepted   = 1'b0;

  function automatic void restart_parse();
    parse_state = ST_HEADER;
    hdr_pos     = 4'd0;
    word_acc    = 32'd0;
    label_left  = 8'd0;
    first_label = 1'b1;
    rdata_left  = 16'd0;
    halted      = 1'b0;
  endfunction

  function automatic void emit(input logic [4:0] code, input logic [31:0] value);
    step_evs.push_back('{code, value, 1'b0});
  endfunction

  task automatic parse_octet(input logic [7:0] b, input logic start);
    logic [15:0] w;
    logic [4:0]  code;
    step_evs.delete();
    if (start)
      restart_parse();
    if (halted)
      return;
    w = {word_acc[7:0], b};
    case (parse_state)
      ST_HEADER: begin
        if (hdr_pos == 4'd2) begin
          emit(FC_QR, 32'(b[7]));
          emit(FC_OPCODE, 32'(b[6:3]));
          emit(FC_AA, 32'(b[2]));
          emit(FC_TC, 32'(b[1]));
          emit(FC_RD, 32'(b[0]));
        end else if (hdr_pos == 4'd3) begin
          emit(FC_RA, 32'(b[7]));
          emit(FC_Z, 32'(b[6:4]));
          emit(FC_RCODE, 32'(b[3:0]));
          if (resp_mode && b[3:0] != 4'd0)
            halted = 1'b1;
        end else if (!hdr_pos[0]) begin
          word_acc = 32'(b);
        end else begin
          case (hdr_pos)
            4'd1:    code = FC_ID;
            4'd5:    code = FC_QDCOUNT;
            4'd7:    code = FC_ANCOUNT;
            4'd9:    code = FC_NSCOUNT;
            default: code = FC_ARCOUNT;
          endcase
          emit(code, 32'(w));
        end
        if (hdr_pos >= 4'd11) begin
          parse_state = ST_NAME_LEN;
          hdr_pos     = 4'd0;
        end else begin
          hdr_pos = hdr_pos + 4'd1;
        end
      end
      ST_NAME_LEN: begin
        if (b == 8'd0) begin
          emit(FC_NAME_END, 32'd0);
          parse_state = ST_TYPE;
          hdr_pos     = 4'd0;
        end else begin
          if (!first_label)
            emit(FC_NAME_CHAR, 32'(DOT_CHAR));
          first_label = 1'b0;
          label_left  = b;
          parse_state = ST_NAME_LABEL;
        end
      end
      ST_NAME_LABEL: begin
        emit(FC_NAME_CHAR, 32'(b));
        label_left = label_left - 8'd1;
        if (label_left == 8'd0)
          parse_state = ST_NAME_LEN;
      end
      ST_TYPE, ST_CLASS, ST_RDLEN: begin
        if (hdr_pos == 4'd0) begin
          word_acc = 32'(b);
          hdr_pos  = 4'd1;
        end else begin
          hdr_pos = 4'd0;
          if (parse_state == ST_TYPE) begin
            emit(FC_TYPE, 32'(w));
            parse_state = ST_CLASS;
          end else if (parse_state == ST_CLASS) begin
            emit(FC_CLASS, 32'(w));
            if (resp_mode)
              parse_state = ST_TTL;
            else
              halted = 1'b1;
          end else begin
            emit(FC_RDLENGTH, 32'(w));
            rdata_left = w;
            if (w == 16'd0)
              halted = 1'b1;
            else
              parse_state = ST_RDATA;
          end
        end
      end
      ST_TTL: begin
        word_acc = {word_acc[23:0], b};
        if (hdr_pos >= 4'd3) begin
          emit(FC_TTL, word_acc);
          hdr_pos     = 4'd0;
          parse_state = ST_RDLEN;
        end else begin
          hdr_pos = hdr_pos + 4'd1;
        end
      end
      ST_RDATA: begin
        emit(FC_RDATA, 32'(b));
        rdata_left = rdata_left - 16'd1;
        if (rdata_left == 16'd0)
          halted = 1'b1;
      end
      default: halted = 1'b1;
    endcase
    if (step_evs.size() != 0)
      step_evs[step_evs.size() - 1].last = 1'b1;
    foreach (step_evs[i])
      event_q.push_back(step_evs[i]);
  endtask

  function automatic void push_octet(input logic [7:0] v, input logic s, input logic h);
    octet_q.push_back('{v, s, h});
    octets_pushed++;
  endfunction

  // one message, sometimes cut short, sometimes without its start mark,
  // sometimes followed by stray bytes
  task automatic queue_message(input logic resp, input int k, output int n);
    logic [7:0] msg[$];
    logic [3:0] rcode;
    logic       no_start;
    logic       hold;
    int         nlab;
    int         len;
    int         rdlen;
    int         cut;
    if (resp)
      rcode = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
    else
      rcode = 4'($urandom);
    hold     = (k == 2) || ($urandom_range(0, 9) == 0);
    no_start = ($urandom_range(0, 14) == 0);
    repeat (3) msg.push_back(8'($urandom));
    msg.push_back({4'($urandom), rcode});
    repeat (8) msg.push_back(8'($urandom));
    if (!(resp && rcode != 4'd0)) begin
      nlab = $urandom_range(0, 4);
      repeat (nlab) begin
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(64, 72) : $urandom_range(1, 12);
        msg.push_back(8'(len));
        repeat (len) msg.push_back(8'($urandom));
      end
      msg.push_back(8'h00);
      repeat (4) msg.push_back(8'($urandom));
      if (resp) begin
        rdlen = (k == 0 || $urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
        repeat (4) msg.push_back(8'($urandom));
        msg.push_back(8'(rdlen >> 8));
        msg.push_back(8'(rdlen));
        repeat (rdlen) msg.push_back(8'($urandom));
      end
    end
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, msg.size() - 1) : msg.size();
    for (int i = 0; i < cut; i++)
      push_octet(msg[i], (i == 0) && !no_start, (i == 0) && hold);
    n = no_start ? 0 : cut;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) push_octet(8'($urandom), 1'b0, 1'b0);
  endtask

  task automatic run_random(input logic resp, input int target);
    int n;
    int count;
    int k;
    count = 0;
    k     = 0;
    while (count < target) begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 5))
          push_octet(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
      queue_message(resp, k, n);
      count += n;
      k++;
    end
  endtask

  task automatic wait_idle();
    while (octets_taken != octets_pushed || event_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_kind(input logic kind);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= kind;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    resp_mode = 1'b0;
    restart_parse();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // no start mark after reset, all-ones header, nonzero RCODE in question mode,
    // empty name
    repeat (12) push_octet(8'hff, 1'b0, 1'b0);
    push_octet(8'h00, 1'b0, 1'b0);
    push_octet(8'hff, 1'b0, 1'b0);
    push_octet(8'hff, 1'b0, 1'b0);
    push_octet(8'h00, 1'b0, 1'b0);
    push_octet(8'h00, 1'b0, 1'b0);
    run_random(1'b0, 60);
    wait_idle();

    write_kind(1'b1);
    // response stopped by RCODE, then a stray byte
    push_octet(8'h00, 1'b1, 1'b0);
    push_octet(8'h00, 1'b0, 1'b0);
    push_octet(8'h00, 1'b0, 1'b0);
    push_octet(8'h8f, 1'b0, 1'b0);
    repeat (8) push_octet(8'h00, 1'b0, 1'b0);
    push_octet(8'h5a, 1'b0, 1'b0);
    run_random(1'b1, 70);
    wait_idle();

    write_kind(1'b0);
    run_random(1'b0, 60);
    wait_idle();

    write_kind(1'b1);
    run_random(1'b1, 70);
    wait_idle();

    if (errors == 0 && event_q.size() == 0)
      $display("** dns_message_parser: PASSED **");
    else
      $display("** dns_message_parser: FAILED **");
    $finish;
  end

  always @(negedge clk) begin : driver
    msg_octet_t nxt;
    if (!rst && (!s_axis_tvalid || in_accepted)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (octet_q.size() != 0 && !(octet_q[0].hold && event_q.size() != 0)) begin
        nxt = octet_q.pop_front();
        s_axis_tdata  <= nxt.octet;
        s_axis_tuser  <= nxt.start;
        s_axis_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    rx_cycle++;
    case ((rx_cycle / 97) % 4)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= (rx_cycle % 5 == 0);
      default: m_axis_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin : monitor
    field_event_t want;
    in_accepted = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready)
        resp_mode = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        in_accepted = 1'b1;
        octets_taken++;
        parse_octet(s_axis_tdata, s_axis_tuser);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (event_q.size() == 0) begin
          $error("unexpected transaction: field_code %0d field_value 0x%08h",
                 m_axis_tuser, m_axis_tdata);
          errors++;
        end else begin
          want = event_q.pop_front();
          if (m_axis_tuser !== want.code) begin
            $error("field_code: expected %0d, got %0d", want.code, m_axis_tuser);
            errors++;
          end
          if (m_axis_tdata !== want.value) begin
            $error("field_value: expected 0x%08h, got 0x%08h", want.value, m_axis_tdata);
            errors++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_of_run: expected %0b, got %0b", want.last, m_axis_tlast);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** dns_message_parser: FAILED **");
        $finish;
      end
    end
  end

endmodule

// File: sim.f
sv/dmp_pkg.sv
sv/dmp_front.sv
sv/dmp_queue.sv
sv/dmp_back.sv
sv/dns_message_parser.sv
sv/dmp_checker.sv
dv/dns_message_parser_test.sv
